// ===== rtl/gdc_pkg.sv =====
// shared constants and item types for the grid declutter block
// no dependencies; imported by every module of the block
package gdc_pkg;

    localparam int MAX_CELLS     = 4096;
    localparam int COORD_BITS    = 16;
    localparam int INT_BITS      = 20;
    localparam int CELL_NUM_BITS = 12;
    localparam int CS_BITS       = 8;
    localparam int GRID_BITS     = 13;
    localparam int CELL_BITS     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int PROD_BITS     = COORD_BITS + GRID_BITS;
    localparam int SUM_BITS      = PROD_BITS + 1;
    localparam int CMP_BITS      = 17;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_TOP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CELL_SIZE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_COLS  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_ROWS  = 3'd6;

    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [COORD_BITS-1:0]    pos_x;
        logic [COORD_BITS-1:0]    pos_y;
        logic [INT_BITS-1:0]      intensity;
        logic                     on_map;
        logic [CELL_NUM_BITS-1:0] cell_sel;
    } t_cmd;

    typedef struct packed {
        logic                     hit;
        logic [CELL_NUM_BITS-1:0] cell_num;
        logic [COORD_BITS-1:0]    out_x;
        logic [COORD_BITS-1:0]    out_y;
        logic [INT_BITS-1:0]      out_intensity;
    } t_res;

    // one cell entry of the survivor memory
    typedef struct packed {
        logic                  valid;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [INT_BITS-1:0]   inten;
    } t_cell_word;

endpackage

// ===== rtl/gdc_div.sv =====
// bit-serial divider: column and row offsets divided by the cell size, both lanes together
// depends on gdc_pkg
module gdc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [gdc_pkg::COORD_BITS-1:0] i_dx,
    input  logic [gdc_pkg::COORD_BITS-1:0] i_dy,
    input  logic [gdc_pkg::CS_BITS-1:0]    i_divisor,
    output logic                           o_done,
    output logic [gdc_pkg::COORD_BITS-1:0] o_col,
    output logic [gdc_pkg::COORD_BITS-1:0] o_row
);
    import gdc_pkg::*;

    localparam int CNT_BITS = $clog2(COORD_BITS);

    logic                  r_run, n_run;
    logic                  r_done, n_done;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [COORD_BITS-1:0] r_qx, n_qx, r_qy, n_qy;
    logic [CS_BITS-1:0]    r_rx, n_rx, r_ry, n_ry;
    logic [CS_BITS-1:0]    r_d, n_d;
    logic [CS_BITS:0]      w_tx, w_ty;

    assign w_tx = {r_rx, r_qx[COORD_BITS-1]};
    assign w_ty = {r_ry, r_qy[COORD_BITS-1]};

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_qx   = r_qx;
        n_qy   = r_qy;
        n_rx   = r_rx;
        n_ry   = r_ry;
        n_d    = r_d;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_qx  = i_dx;
            n_qy  = i_dy;
            n_rx  = '0;
            n_ry  = '0;
            n_d   = i_divisor;
        end else if (r_run) begin
            // restoring step, one quotient bit per lane
            if (w_tx >= {1'b0, r_d}) begin
                n_rx = CS_BITS'(w_tx - {1'b0, r_d});
                n_qx = {r_qx[COORD_BITS-2:0], 1'b1};
            end else begin
                n_rx = w_tx[CS_BITS-1:0];
                n_qx = {r_qx[COORD_BITS-2:0], 1'b0};
            end
            if (w_ty >= {1'b0, r_d}) begin
                n_ry = CS_BITS'(w_ty - {1'b0, r_d});
                n_qy = {r_qy[COORD_BITS-2:0], 1'b1};
            end else begin
                n_ry = w_ty[CS_BITS-1:0];
                n_qy = {r_qy[COORD_BITS-2:0], 1'b0};
            end
            n_cnt = CNT_BITS'(r_cnt + 1'b1);
            if (r_cnt == CNT_BITS'(COORD_BITS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qx <= n_qx;
        r_qy <= n_qy;
        r_rx <= n_rx;
        r_ry <= n_ry;
        r_d  <= n_d;
    end

    assign o_done = r_done;
    assign o_col  = r_qx;
    assign o_row  = r_qy;

endmodule

// ===== rtl/gdc_cell_ram.sv =====
// survivor memory: one entry per grid cell, one write and one registered read port
// depends on gdc_pkg
module gdc_cell_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [gdc_pkg::CELL_BITS-1:0] i_waddr,
    input  gdc_pkg::t_cell_word           i_wdata,
    input  logic                          i_re,
    input  logic [gdc_pkg::CELL_BITS-1:0] i_raddr,
    output gdc_pkg::t_cell_word           o_rdata
);
    import gdc_pkg::*;

    t_cell_word r_mem [MAX_CELLS];
    t_cell_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/grid_declutter_max_per_cell_unit.sv =====
// top level of the grid declutter block: configuration, filter, cell address and update
// depends on gdc_pkg, gdc_div and gdc_cell_ram
//
// usage
// - items enter on start/i_cmd and are taken at an edge where start is high and busy is low.
//   one item is worked on at a time; busy stays high until its result has been issued.
// - every item gives exactly one result on o_res, marked by o_res_vld for one cycle.
//   the receiver cannot hold results off; nothing waits for it.
// - an offer dropped by the box, position or on_map filter: result in the cycle after accept.
// - a read of a cell: result after one memory read and one write-back.
// - an offer that reaches the grid: the bit-serial divider forms column and row and raises
//   its done flag; then a multiply, an address add and the read-modify-write of the cell
//   memory give the result. an offer that misses the grid drops at the multiply, one past
//   the cell memory at the address add.
// - the next item can be taken at the edge where the previous result is taken.
// - configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_wdata), taken at once;
//   the user writes it only while the block is idle; the block itself does not enforce this.
// - after reset the block clears the valid flag of all MAX_CELLS cells, one per cycle,
//   and holds busy high meanwhile; configuration writes still go in.
module grid_declutter_max_per_cell_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  gdc_pkg::t_cmd                     i_cmd,
    output logic                              o_res_vld,
    output gdc_pkg::t_res                     o_res,
    input  logic                              i_cfg_we,
    input  logic [gdc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [gdc_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata
);
    import gdc_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_ADDR  = 6'b010000,
        ST_RMW   = 6'b100000
    } t_state;

    t_state                r_state, n_state;

    // configuration
    logic [COORD_BITS-1:0] r_map_left, r_map_top, r_map_width, r_map_height;
    logic [CS_BITS-1:0]    r_cell_size;
    logic [GRID_BITS-1:0]  r_grid_cols, r_grid_rows;

    logic [CELL_BITS-1:0]  r_clr_cnt, n_clr_cnt;
    t_cmd                  r_cmd, n_cmd;
    logic [CELL_BITS-1:0]  r_cell, n_cell;
    logic                  r_sel_ok, n_sel_ok;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [PROD_BITS-1:0]  r_prod, n_prod;
    logic                  r_res_vld, n_res_vld;
    t_res                  r_res, n_res;

    logic                  w_acc;
    logic                  w_in_x, w_in_y, w_keep;
    logic [CS_BITS-1:0]    w_cs;
    logic                  w_div_start, w_div_done;
    logic [COORD_BITS-1:0] w_div_col, w_div_row;
    logic [SUM_BITS-1:0]   w_sum;
    logic                  w_in_grid;

    logic                  w_we, w_re;
    logic [CELL_BITS-1:0]  w_waddr, w_raddr;
    t_cell_word            w_wdata, w_rdata, w_new;
    logic                  w_take;

    assign busy  = (r_state != ST_IDLE);
    assign w_acc = start && !busy;

    // box test, sums at 17 bits so they never wrap
    assign w_in_x = (i_cmd.pos_x >= r_map_left) &&
                    ({1'b0, i_cmd.pos_x} < ({1'b0, r_map_left} + {1'b0, r_map_width}));
    assign w_in_y = (i_cmd.pos_y >= r_map_top) &&
                    ({1'b0, i_cmd.pos_y} < ({1'b0, r_map_top} + {1'b0, r_map_height}));
    assign w_keep = !((i_cmd.pos_x == '0) && (i_cmd.pos_y == '0)) && i_cmd.on_map &&
                    w_in_x && w_in_y;
    assign w_cs   = (r_cell_size == '0) ? CS_BITS'(1) : r_cell_size;

    assign w_div_start = w_acc && (i_cmd.action == ACT_OFFER) && w_keep;

    gdc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dx      (COORD_BITS'(i_cmd.pos_x - r_map_left)),
        .i_dy      (COORD_BITS'(i_cmd.pos_y - r_map_top)),
        .i_divisor (w_cs),
        .o_done    (w_div_done),
        .o_col     (w_div_col),
        .o_row     (w_div_row)
    );

    assign w_in_grid = (CMP_BITS'(w_div_col) < CMP_BITS'(r_grid_cols)) &&
                       (CMP_BITS'(w_div_row) < CMP_BITS'(r_grid_rows));
    assign w_sum     = SUM_BITS'(r_prod) + SUM_BITS'(r_col);

    // update of one cell from the word read back
    assign w_new  = '{valid: 1'b1, x: r_cmd.pos_x, y: r_cmd.pos_y, inten: r_cmd.intensity};
    assign w_take = !w_rdata.valid || (r_cmd.intensity > w_rdata.inten);

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_cmd     = r_cmd;
        n_cell    = r_cell;
        n_sel_ok  = r_sel_ok;
        n_col     = r_col;
        n_prod    = r_prod;
        n_res_vld = 1'b0;
        n_res     = r_res;
        w_we      = 1'b0;
        w_waddr   = r_cell;
        w_wdata   = '0;
        w_re      = 1'b0;
        w_raddr   = r_cell;
        case (r_state)
            ST_CLEAR: begin
                w_we      = 1'b1;
                w_waddr   = r_clr_cnt;
                n_clr_cnt = CELL_BITS'(r_clr_cnt + 1'b1);
                if (r_clr_cnt == CELL_BITS'(MAX_CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_acc) begin
                    n_cmd = i_cmd;
                    if (i_cmd.action == ACT_READ) begin
                        n_cell   = CELL_BITS'(i_cmd.cell_sel);
                        n_sel_ok = CMP_BITS'(i_cmd.cell_sel) < CMP_BITS'(MAX_CELLS);
                        w_re     = 1'b1;
                        w_raddr  = CELL_BITS'(i_cmd.cell_sel);
                        n_state  = ST_RMW;
                    end else if (w_keep) begin
                        n_state = ST_DIV;
                    end else begin
                        n_res_vld = 1'b1;
                        n_res     = '0;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_col  = w_div_col;
                n_prod = PROD_BITS'(w_div_row) * PROD_BITS'(r_grid_cols);
                if (w_in_grid) begin
                    n_state = ST_ADDR;
                end else begin
                    n_res_vld = 1'b1;
                    n_res     = '0;
                    n_state   = ST_IDLE;
                end
            end
            ST_ADDR: begin
                n_cell = CELL_BITS'(w_sum);
                if (w_sum < SUM_BITS'(MAX_CELLS)) begin
                    w_re    = 1'b1;
                    w_raddr = CELL_BITS'(w_sum);
                    n_state = ST_RMW;
                end else begin
                    n_res_vld = 1'b1;
                    n_res     = '0;
                    n_state   = ST_IDLE;
                end
            end
            ST_RMW: begin
                n_res_vld = 1'b1;
                n_state   = ST_IDLE;
                if (r_cmd.action == ACT_READ) begin
                    // read clears the cell
                    w_we              = r_sel_ok;
                    w_wdata           = '0;
                    n_res             = '0;
                    n_res.cell_num    = r_cmd.cell_sel;
                    if (r_sel_ok && w_rdata.valid) begin
                        n_res.hit           = 1'b1;
                        n_res.out_x         = w_rdata.x;
                        n_res.out_y         = w_rdata.y;
                        n_res.out_intensity = w_rdata.inten;
                    end
                end else begin
                    w_we           = w_take;
                    w_wdata        = w_new;
                    n_res.hit      = w_take;
                    n_res.cell_num = CELL_NUM_BITS'(r_cell);
                    if (w_take) begin
                        n_res.out_x         = w_new.x;
                        n_res.out_y         = w_new.y;
                        n_res.out_intensity = w_new.inten;
                    end else begin
                        n_res.out_x         = w_rdata.x;
                        n_res.out_y         = w_rdata.y;
                        n_res.out_intensity = w_rdata.inten;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    gdc_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cell   <= n_cell;
        r_sel_ok <= n_sel_ok;
        r_col    <= n_col;
        r_prod   <= n_prod;
        r_res    <= n_res;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_left   <= '0;
            r_map_top    <= '0;
            r_map_width  <= '0;
            r_map_height <= '0;
            r_cell_size  <= CS_BITS'(16);
            r_grid_cols  <= GRID_BITS'(1);
            r_grid_rows  <= GRID_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAP_LEFT:   r_map_left   <= i_cfg_wdata;
                CFG_MAP_TOP:    r_map_top    <= i_cfg_wdata;
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_wdata;
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_wdata;
                CFG_CELL_SIZE:  r_cell_size  <= i_cfg_wdata[CS_BITS-1:0];
                CFG_GRID_COLS:  r_grid_cols  <= i_cfg_wdata[GRID_BITS-1:0];
                CFG_GRID_ROWS:  r_grid_rows  <= i_cfg_wdata[GRID_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

endmodule
